FILE: rtl/core/tsma_pkg.sv
`timescale 1ns / 1ps
package tsma_pkg;

    localparam int MaxWindow = 16;
    localparam int RingAw    = $clog2(MaxWindow);
    localparam int WinW      = 5;
    localparam int RemW      = WinW - 1;
    localparam int AngW      = 32;
    localparam int DeltaW    = 32;
    localparam int SumW      = 37;
    localparam int MagW      = SumW - 1;
    localparam int DivSteps  = MagW;
    localparam int CntW      = $clog2(DivSteps);

    typedef struct packed {
        logic accept;
        logic add;
        logic load;
        logic step;
        logic finish;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic smooth_turn;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/core/tsma_if.sv
`timescale 1ns / 1ps
interface tsma_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic signed [tsma_pkg::DeltaW-1:0]    turn_delta;
    logic        [tsma_pkg::AngW-1:0]      body_angle;

    modport source (output valid, req_type, turn_delta, body_angle, input ready);
    modport sink   (input valid, req_type, turn_delta, body_angle, output ready);
endinterface

interface tsma_out_if;
    logic                           valid;
    logic                           ready;
    logic [tsma_pkg::AngW-1:0]      view_angle;

    modport source (output valid, view_angle, input ready);
    modport sink   (input valid, view_angle, output ready);
endinterface

FILE: rtl/core/tsma_ctrl.sv
`timescale 1ns / 1ps
module tsma_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tsma_pkg::t_dp_status  i_status,
    output tsma_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SUM   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_DIV   = 6'b001000,
        S_ANGLE = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [tsma_pkg::CntW-1:0]   r_cnt, n_cnt;
    logic                        w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.smooth_turn ? S_SUM : S_EMIT;
                end
            end
            S_SUM: begin
                o_cmd.add = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = tsma_pkg::CntW'(tsma_pkg::DivSteps - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_ANGLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ANGLE: begin
                o_cmd.finish = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_turn_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_status.smooth_turn |=> r_state == S_SUM)
        else $error("smoothed turn did not start the sum update");

    a_plain_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_status.smooth_turn |=> r_state == S_EMIT)
        else $error("restart or bypass item did not go straight to emit");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt == '0 |=> r_state == S_ANGLE)
        else $error("divider did not finish after its last step");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result emitted into a full output register");

endmodule

FILE: rtl/core/tsma_dp.sv
`timescale 1ns / 1ps
module tsma_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsma_pkg::t_ctrl_cmd                 i_cmd,
    output tsma_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_enable,
    input  logic [tsma_pkg::WinW-1:0]           i_cfg_window,
    input  logic                                i_req_type,
    input  logic signed [tsma_pkg::DeltaW-1:0]  i_turn_delta,
    input  logic [tsma_pkg::AngW-1:0]           i_body_angle,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [tsma_pkg::AngW-1:0]           o_view_angle
);

    logic signed [tsma_pkg::DeltaW-1:0]  r_ring [tsma_pkg::MaxWindow];
    logic [tsma_pkg::MaxWindow-1:0]      r_ring_vld;
    logic signed [tsma_pkg::SumW-1:0]    r_sum;
    logic [tsma_pkg::RingAw-1:0]         r_idx;
    logic [tsma_pkg::AngW-1:0]           r_angle;
    logic [tsma_pkg::AngW-1:0]           r_result;
    logic signed [tsma_pkg::DeltaW-1:0]  r_delta;
    logic [tsma_pkg::MagW-1:0]           r_mag;
    logic                                r_neg;
    logic [tsma_pkg::RemW-1:0]           r_rem;
    logic [tsma_pkg::WinW-1:0]           r_mod;
    logic                                r_out_vld;
    logic [tsma_pkg::AngW-1:0]           r_view;

    logic [tsma_pkg::WinW-1:0]           w_win;
    logic signed [tsma_pkg::DeltaW-1:0]  w_old;
    logic signed [tsma_pkg::SumW-1:0]    n_sum;
    logic [tsma_pkg::SumW-1:0]           w_abs;
    logic [tsma_pkg::WinW-1:0]           w_rem_sh;
    logic                                w_qbit;
    logic [tsma_pkg::RemW-1:0]           n_rem;
    logic [tsma_pkg::MagW-1:0]           n_mag;
    logic [tsma_pkg::WinW-1:0]           n_mod;
    logic [tsma_pkg::MagW-1:0]           w_quot;
    logic [tsma_pkg::AngW-1:0]           n_angle;
    logic                                w_restart;

    assign o_status.smooth_turn = i_cfg_enable && i_req_type;
    assign o_status.out_free    = !r_out_vld || i_out_ready;
    assign o_out_valid          = r_out_vld;
    assign o_view_angle         = r_view;
    assign w_restart            = i_cmd.accept && i_cfg_enable && !i_req_type;

    always_comb begin
        if (i_cfg_window == '0) begin
            w_win = tsma_pkg::WinW'(1);
        end else if (i_cfg_window > tsma_pkg::WinW'(tsma_pkg::MaxWindow)) begin
            w_win = tsma_pkg::WinW'(tsma_pkg::MaxWindow);
        end else begin
            w_win = i_cfg_window;
        end
    end

    // running sum update, restoring divide step, index wrap and angle add
    always_comb begin
        w_old = r_ring_vld[r_idx] ? r_ring[r_idx] : '0;
        n_sum = r_sum - tsma_pkg::SumW'(w_old) + tsma_pkg::SumW'(r_delta);
        w_abs = r_sum[tsma_pkg::SumW-1] ? (~r_sum + 1'b1) : r_sum;

        w_rem_sh = {r_rem, r_mag[tsma_pkg::MagW-1]};
        w_qbit   = (w_rem_sh >= w_win);
        n_rem    = w_qbit ? tsma_pkg::RemW'(w_rem_sh - w_win)
                          : w_rem_sh[tsma_pkg::RemW-1:0];
        n_mag    = {r_mag[tsma_pkg::MagW-2:0], w_qbit};
        n_mod    = (r_mod >= w_win) ? (r_mod - w_win) : r_mod;

        w_quot  = r_neg ? (~r_mag + 1'b1) : r_mag;
        n_angle = r_angle + w_quot[tsma_pkg::AngW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_sum      <= '0;
            r_idx      <= '0;
            r_angle    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_restart) begin
                r_ring_vld <= '0;
                r_sum      <= '0;
                r_idx      <= '0;
                r_angle    <= i_body_angle;
            end
            if (i_cmd.add) begin
                r_ring_vld[r_idx] <= 1'b1;
                r_sum             <= n_sum;
            end
            if (i_cmd.finish) begin
                r_angle <= n_angle;
                r_idx   <= r_mod[tsma_pkg::RingAw-1:0];
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_result <= i_body_angle;
            r_delta  <= i_turn_delta;
        end
        if (i_cmd.add) begin
            r_ring[r_idx] <= r_delta;
        end
        if (i_cmd.load) begin
            r_neg <= r_sum[tsma_pkg::SumW-1];
            r_mag <= w_abs[tsma_pkg::MagW-1:0];
            r_rem <= '0;
            r_mod <= tsma_pkg::WinW'(r_idx) + 1'b1;
        end
        if (i_cmd.step) begin
            r_rem <= n_rem;
            r_mag <= n_mag;
            r_mod <= n_mod;
        end
        if (i_cmd.finish) begin
            r_result <= n_angle;
        end
        if (i_cmd.emit) begin
            r_view <= r_result;
        end
    end

endmodule

FILE: rtl/core/turn_smoothing_moving_average_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// i_in      in   valid/ready   req_type, turn_delta, body_angle
// o_out     out  valid/ready   view_angle
// apb       in   psel/penable  paddr, pwdata, prdata (0: smoothing_enable, 4: window_length)
//
// a smoothed turn item goes from accept to result through sum update, divider load,
// 36 bit-serial restoring divide steps on the sum's 36-bit magnitude, angle add, emit
// restart items and items with smoothing off go from accept straight to emit
// one item is in work at a time; a finished result waits in the output register
// a stalled output holds the next result in emit until the register frees
// synchronous active-low reset clears ring valid bits, sum, index, angle, out valid, enable
module turn_smoothing_moving_average_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsma_in_if.sink       i_in,
    tsma_out_if.source    o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam logic RegEnable = 1'b0;
    localparam logic RegWindow = 1'b1;

    logic                           r_cfg_enable;
    logic [tsma_pkg::WinW-1:0]      r_cfg_window;
    logic                           w_cfg_wr;
    logic                           w_reg_idx;
    tsma_pkg::t_ctrl_cmd            w_cmd;
    tsma_pkg::t_dp_status           w_status;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    always_comb begin
        unique case (w_reg_idx)
            RegEnable: prdata = {31'd0, r_cfg_enable};
            RegWindow: prdata = {{(32 - tsma_pkg::WinW){1'b0}}, r_cfg_window};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable <= 1'b0;
            r_cfg_window <= tsma_pkg::WinW'(6);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                RegEnable: r_cfg_enable <= pwdata[0];
                RegWindow: r_cfg_window <= pwdata[tsma_pkg::WinW-1:0];
                default:   r_cfg_enable <= r_cfg_enable;
            endcase
        end
    end

    tsma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tsma_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_enable (r_cfg_enable),
        .i_cfg_window (r_cfg_window),
        .i_req_type   (i_in.req_type),
        .i_turn_delta (i_in.turn_delta),
        .i_body_angle (i_in.body_angle),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_view_angle (o_out.view_angle)
    );

endmodule

FILE: test/tb_turn_smoothing_moving_average_core.sv
`timescale 1ns / 1ps
module tb_turn_smoothing_moving_average_core;

    localparam bit ReqRestart = 1'b0;
    localparam bit ReqTurn    = 1'b1;

    localparam logic [2:0] AddrEnable = 3'd0;
    localparam logic [2:0] AddrWindow = 3'd4;

    localparam logic signed [tsma_pkg::DeltaW-1:0] DeltaMax = 32'h7fff_ffff;
    localparam logic signed [tsma_pkg::DeltaW-1:0] DeltaMin = 32'h8000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tsma_in_if  in_bus ();
    tsma_out_if out_bus ();

    turn_smoothing_moving_average_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // smoother state as the block should hold it
    logic signed [tsma_pkg::DeltaW-1:0] turn_ring [tsma_pkg::MaxWindow];
    logic signed [tsma_pkg::SumW-1:0]   turn_sum;
    logic [tsma_pkg::RingAw-1:0]        turn_slot;
    logic [tsma_pkg::AngW-1:0]          smoothed_angle;
    bit                                 cfg_smooth_en;
    logic [tsma_pkg::WinW-1:0]          cfg_window;

    logic [tsma_pkg::AngW-1:0] view_expect_q [$];

    int  errors;
    int  n_items;
    int  n_turns;
    int  n_restarts;
    int  n_results;
    int  n_writes;
    int  n_phases;
    bit  feed_up;
    bit  calm_in;
    bit  calm_out;
    int  view_wait;
    int  pause;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void clear_turns();
        for (int i = 0; i < tsma_pkg::MaxWindow; i++) begin
            turn_ring[i] = '0;
        end
        turn_sum  = '0;
        turn_slot = '0;
    endfunction

    function automatic logic [tsma_pkg::AngW-1:0] predict_view(
        input bit                                 req,
        input logic signed [tsma_pkg::DeltaW-1:0] delta,
        input logic [tsma_pkg::AngW-1:0]          body);
        int     w;
        longint quot;
        if (!cfg_smooth_en) begin
            return body;
        end
        if (req == ReqRestart) begin
            smoothed_angle = body;
            clear_turns();
        end else begin
            w = (cfg_window == 0) ? 1 :
                (cfg_window > tsma_pkg::MaxWindow) ? tsma_pkg::MaxWindow : int'(cfg_window);
            turn_sum = turn_sum - turn_ring[turn_slot] + delta;
            turn_ring[turn_slot] = delta;
            turn_slot = tsma_pkg::RingAw'((int'(turn_slot) + 1) % w);
            quot = longint'(turn_sum) / longint'(w);
            smoothed_angle = smoothed_angle + tsma_pkg::AngW'(quot);
        end
        return smoothed_angle;
    endfunction

    function automatic logic signed [tsma_pkg::DeltaW-1:0] draw_delta();
        logic [31:0] mag;
        case ($urandom_range(0, 6))
            0: return DeltaMax;
            1: return DeltaMin;
            2: return tsma_pkg::DeltaW'($urandom_range(0, 2000)) - tsma_pkg::DeltaW'(1000);
            3: begin
                mag = $urandom >> $urandom_range(1, 28);
                return ($urandom_range(0, 1) != 0) ? -$signed(mag) : $signed(mag);
            end
            4: return ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input bit req, input logic signed [tsma_pkg::DeltaW-1:0] delta,
                             input logic [tsma_pkg::AngW-1:0] body);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            if (feed_up) begin
                in_bus.valid <= 1'b0;
            end
            feed_up = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.req_type   <= req;
        in_bus.turn_delta <= delta;
        in_bus.body_angle <= body;
        feed_up = 1'b1;
        do @(posedge i_clk); while (!in_bus.ready);
        view_expect_q.push_back(predict_view(req, delta, body));
        n_items++;
        if (req == ReqTurn) begin
            n_turns++;
        end else begin
            n_restarts++;
        end
    endtask

    task automatic park_input();
        if (feed_up) begin
            in_bus.valid <= 1'b0;
            feed_up = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        while (view_expect_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
        @(posedge i_clk);
    endtask

    task automatic read_reg(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            report_mismatch($sformatf("register %0d read %h, expected %h", addr, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // only while idle: input parked and every result back
    task automatic set_config(input bit en, input logic [tsma_pkg::WinW-1:0] win);
        logic [31:0] word;
        park_input();
        wait_drain();
        word = $urandom;
        word[0] = en;
        write_reg(AddrEnable, word);
        cfg_smooth_en = en;
        word = $urandom;
        word[tsma_pkg::WinW-1:0] = win;
        write_reg(AddrWindow, word);
        cfg_window = win;
        read_reg(AddrEnable, {31'b0, en});
        read_reg(AddrWindow, {{(32-tsma_pkg::WinW){1'b0}}, win});
    endtask

    // result side: per-transaction stall, none in calm stretches
    initial begin
        out_bus.ready <= 1'b0;
        view_wait = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_bus.ready <= 1'b0;
                view_wait = 0;
            end else if (out_bus.valid && out_bus.ready) begin
                pause = calm_out ? 0 : $urandom_range(0, 18);
                view_wait = pause;
                out_bus.ready <= (pause == 0);
            end else if (view_wait > 0) begin
                view_wait--;
                out_bus.ready <= (view_wait == 0);
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            n_results++;
            if (view_expect_q.size() == 0) begin
                report_mismatch($sformatf("view_angle %h with nothing pending",
                                          out_bus.view_angle));
            end else if (out_bus.view_angle !== view_expect_q[0]) begin
                report_mismatch($sformatf("view_angle %h, expected %h",
                                          out_bus.view_angle, view_expect_q[0]));
                void'(view_expect_q.pop_front());
            end else begin
                void'(view_expect_q.pop_front());
            end
        end
    end

    task automatic test_reset_defaults();
        read_reg(AddrEnable, 32'd0);
        read_reg(AddrWindow, 32'd6);
        send_item(ReqRestart, DeltaMax, 32'h0000_0000);
        send_item(ReqTurn, DeltaMax, 32'hffff_ffff);
        send_item(ReqTurn, DeltaMin, 32'h8000_0000);
        // enable only, window keeps its reset value
        park_input();
        wait_drain();
        write_reg(AddrEnable, 32'd1);
        cfg_smooth_en = 1'b1;
        send_item(ReqRestart, 32'sd0, 32'h1234_5678);
        send_item(ReqTurn, DeltaMax, 32'h0);
        send_item(ReqTurn, DeltaMin, 32'h0);
    endtask

    task automatic test_window_limits();
        set_config(1'b1, 5'd0);
        send_item(ReqTurn, -32'sd1, 32'h0);
        send_item(ReqTurn, DeltaMax, 32'h0);
        set_config(1'b1, 5'd31);
        send_item(ReqTurn, DeltaMin, 32'h0);
        send_item(ReqTurn, 32'sd5, 32'h0);
        set_config(1'b1, 5'd16);
        send_item(ReqRestart, 32'sd0, 32'hffff_fff0);
        send_item(ReqTurn, 32'sd1000, 32'h0);
    endtask

    task automatic test_window_shrink();
        set_config(1'b1, 5'd4);
        send_item(ReqRestart, 32'sd0, 32'h0);
        repeat (3) send_item(ReqTurn, DeltaMax, 32'h0);
        // index now past the window
        set_config(1'b1, 5'd2);
        send_item(ReqTurn, DeltaMax, 32'h0);
        // stale entries push the quotient past 32 bits
        set_config(1'b1, 5'd1);
        send_item(ReqTurn, DeltaMax, 32'h0);
    endtask

    task automatic test_disable_hold();
        set_config(1'b0, 5'd1);
        send_item(ReqRestart, 32'sd0, 32'hdead_beef);
        send_item(ReqTurn, 32'sd7, 32'h5555_aaaa);
        set_config(1'b1, 5'd1);
        send_item(ReqTurn, 32'sd3, 32'h0);
    endtask

    task automatic test_random_traffic(input int target);
        int                        sent;
        int                        span;
        bit                        en;
        logic [tsma_pkg::WinW-1:0] win;
        sent = 0;
        while (sent < target) begin
            en = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 7))
                0: win = 5'd0;
                1: win = 5'd1;
                2: win = tsma_pkg::WinW'(tsma_pkg::MaxWindow);
                3: win = tsma_pkg::WinW'($urandom_range(tsma_pkg::MaxWindow + 1, 31));
                default: win = tsma_pkg::WinW'($urandom_range(1, tsma_pkg::MaxWindow));
            endcase
            set_config(en, win);
            calm_in  = ($urandom_range(0, 4) == 0);
            calm_out = ($urandom_range(0, 4) == 0);
            span = $urandom_range(20, 120);
            if ($urandom_range(0, 3) != 0) begin
                send_item(ReqRestart, $urandom, $urandom);
                sent++;
            end
            for (int k = 0; k < span; k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_item(ReqRestart, $urandom, $urandom);
                end else begin
                    send_item(ReqTurn, draw_delta(), $urandom);
                end
            end
            sent += span;
            n_phases++;
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.req_type   <= 1'b0;
        in_bus.turn_delta <= '0;
        in_bus.body_angle <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        errors     = 0;
        n_items    = 0;
        n_turns    = 0;
        n_restarts = 0;
        n_results  = 0;
        n_writes   = 0;
        n_phases   = 0;
        feed_up    = 1'b0;
        calm_in    = 1'b0;
        calm_out   = 1'b0;
        clear_turns();
        smoothed_angle = '0;
        cfg_smooth_en  = 1'b0;
        cfg_window     = 5'd6;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_window_limits();
        test_window_shrink();
        test_disable_hold();
        test_random_traffic(1500);

        park_input();
        wait_drain();
        repeat (60) @(posedge i_clk);
        if (view_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", view_expect_q.size()));
        end
        $display("covered %0d items (%0d turns, %0d restarts), %0d results checked",
                 n_items, n_turns, n_restarts, n_results);
        $display("%0d register writes over %0d random phases, windows 0..31 incl. clamping",
                 n_writes, n_phases);
        if (errors == 0) begin
            $display("tb_turn_smoothing_moving_average_core: clean");
        end else begin
            $display("tb_turn_smoothing_moving_average_core: errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results pending", view_expect_q.size());
        $display("tb_turn_smoothing_moving_average_core: errors");
        $finish;
    end

endmodule
